FILE: hdl/rac_pkg.sv
package rac_pkg;

  localparam int OPERAND_WIDTH = 16;

  localparam int NUM_W = OPERAND_WIDTH;
  localparam int DEN_W = OPERAND_WIDTH - 1;

  // multiplier operands carry one extra bit so denominators stay positive
  localparam int MUL_W  = NUM_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // cross sum, denominator product, gcd and quotients
  localparam int WORK_W = 2 * OPERAND_WIDTH;
  localparam int ALU_W  = WORK_W + 1;
  localparam int CNT_W  = $clog2(WORK_W);
  localparam int K_W    = $clog2(WORK_W);

  localparam int SUM_NUM_W = 32;
  localparam int SUM_DEN_W = 30;

  localparam int IN_DATA_W   = 2 * NUM_W + 2 * DEN_W;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = SUM_NUM_W + SUM_DEN_W + 2;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_D,
    S_SUM,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_DONE
  } rac_state_t;

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
    logic [ALU_W-1:0] abs_diff;
  } rac_alu_t;

  typedef struct packed {
    logic                        a_equal_b;
    logic                        a_less_b;
    logic [SUM_DEN_W-1:0]        sum_den;
    logic signed [SUM_NUM_W-1:0] sum_num;
  } rac_result_t;

endpackage

FILE: hdl/rac_mul.sv
module rac_mul (
  input  logic                                 clk,
  input  logic signed [rac_pkg::MUL_W-1:0]     op_a,
  input  logic signed [rac_pkg::MUL_W-1:0]     op_b,
  output logic signed [rac_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: hdl/rac_alu.sv
module rac_alu (
  input  logic [rac_pkg::ALU_W-1:0] op_a,
  input  logic [rac_pkg::ALU_W-1:0] op_b,
  output rac_pkg::rac_alu_t         res
);

  logic [rac_pkg::ALU_W-1:0] a_minus_b;
  logic [rac_pkg::ALU_W-1:0] b_minus_a;
  logic                      ge;

  assign a_minus_b = op_a - op_b;
  assign b_minus_a = op_b - op_a;
  assign ge        = (op_a >= op_b);

  assign res.ge       = ge;
  assign res.diff     = a_minus_b;
  assign res.abs_diff = ge ? a_minus_b : b_minus_a;

endmodule

FILE: hdl/rac_core.sv
module rac_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [rac_pkg::NUM_W-1:0]    in_a_num,
  input  logic [rac_pkg::DEN_W-1:0]           in_a_den,
  input  logic signed [rac_pkg::NUM_W-1:0]    in_b_num,
  input  logic [rac_pkg::DEN_W-1:0]           in_b_den,
  output logic                                ready,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rac_pkg::rac_result_t                res
);

  localparam int WORK_W = rac_pkg::WORK_W;
  localparam int ALU_W  = rac_pkg::ALU_W;
  localparam int MUL_W  = rac_pkg::MUL_W;

  rac_pkg::rac_state_t state, state_next;

  logic signed [rac_pkg::NUM_W-1:0] a_num, b_num;
  logic [rac_pkg::DEN_W-1:0]        a_den, b_den;
  logic                             eq;

  logic signed [WORK_W-1:0] cross_a, cross_b;
  logic [WORK_W-1:0]        y;
  logic [WORK_W-1:0]        xm;
  logic                     neg;
  logic                     less;

  logic [WORK_W-1:0]        u, v, g;
  logic [rac_pkg::K_W-1:0]  k;
  logic [WORK_W-1:0]        dvd, rem;
  logic [rac_pkg::CNT_W-1:0] cnt;
  logic signed [WORK_W-1:0] res_num;
  logic [WORK_W-1:0]        res_den;

  logic signed [MUL_W-1:0]          mul_a, mul_b;
  logic signed [rac_pkg::PROD_W-1:0] prod;
  logic [ALU_W-1:0]                 alu_a, alu_b;
  rac_pkg::rac_alu_t                alu;

  logic signed [WORK_W-1:0] x_sum;
  logic [WORK_W-1:0]        x_mag;
  logic [WORK_W-1:0]        g_val;
  logic [WORK_W-1:0]        q_next;
  logic [ALU_W-1:0]         rem_sh;
  logic                     u_zero, v_zero, gcd_stop, y_zero, cnt_last;

  rac_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  rac_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu)
  );

  assign x_sum    = cross_a + cross_b;
  assign x_mag    = x_sum[WORK_W-1] ? WORK_W'(-x_sum) : WORK_W'(x_sum);
  assign u_zero   = (u == '0);
  assign v_zero   = (v == '0);
  assign gcd_stop = u_zero || v_zero;
  assign y_zero   = (y == '0);
  assign cnt_last = (cnt == rac_pkg::CNT_W'(WORK_W - 1));
  assign g_val    = (u_zero ? v : u) << k;
  assign rem_sh   = {rem, dvd[WORK_W-1]};
  assign q_next   = {dvd[WORK_W-2:0], alu.ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rac_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    res_valid  = 1'b0;
    mul_a      = MUL_W'(a_den);
    mul_b      = MUL_W'(b_den);
    alu_a      = ALU_W'(u);
    alu_b      = ALU_W'(v);
    unique case (state)
      rac_pkg::S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          state_next = rac_pkg::S_MUL_A;
        end
      end
      rac_pkg::S_MUL_A: begin
        mul_a      = MUL_W'(a_num);
        mul_b      = MUL_W'(b_den);
        state_next = rac_pkg::S_MUL_B;
      end
      rac_pkg::S_MUL_B: begin
        mul_a      = MUL_W'(b_num);
        mul_b      = MUL_W'(a_den);
        state_next = rac_pkg::S_MUL_D;
      end
      rac_pkg::S_MUL_D: begin
        state_next = rac_pkg::S_SUM;
      end
      rac_pkg::S_SUM: begin
        state_next = rac_pkg::S_GCD;
      end
      rac_pkg::S_GCD: begin
        if (gcd_stop) begin
          state_next = y_zero ? rac_pkg::S_DONE : rac_pkg::S_DIV_N;
        end
      end
      rac_pkg::S_DIV_N: begin
        alu_a = rem_sh;
        alu_b = ALU_W'(g);
        if (cnt_last) begin
          state_next = rac_pkg::S_DIV_D;
        end
      end
      rac_pkg::S_DIV_D: begin
        alu_a = rem_sh;
        alu_b = ALU_W'(g);
        if (cnt_last) begin
          state_next = rac_pkg::S_DONE;
        end
      end
      rac_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = rac_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rac_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rac_pkg::S_IDLE: begin
        if (start) begin
          a_num <= in_a_num;
          a_den <= in_a_den;
          b_num <= in_b_num;
          b_den <= in_b_den;
          eq    <= (in_a_num == in_b_num) && (in_a_den == in_b_den);
        end
      end
      rac_pkg::S_MUL_B: begin
        cross_a <= WORK_W'(prod);
      end
      rac_pkg::S_MUL_D: begin
        cross_b <= WORK_W'(prod);
      end
      rac_pkg::S_SUM: begin
        xm   <= x_mag;
        neg  <= x_sum[WORK_W-1];
        less <= (cross_a < cross_b);
        y    <= WORK_W'(prod);
        u    <= x_mag;
        v    <= WORK_W'(prod);
        k    <= '0;
      end
      rac_pkg::S_GCD: begin
        priority if (gcd_stop) begin
          g   <= g_val;
          dvd <= xm;
          rem <= '0;
          cnt <= '0;
          // zero denominator: one over zero, or zero over zero
          res_num <= (u_zero && v_zero) ? '0 : WORK_W'(1);
          res_den <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (alu.ge) begin
          // both odd: the difference is even, halve it at once
          u <= WORK_W'(alu.abs_diff >> 1);
        end else begin
          v <= WORK_W'(alu.abs_diff >> 1);
        end
      end
      rac_pkg::S_DIV_N, rac_pkg::S_DIV_D: begin
        if (cnt_last && state == rac_pkg::S_DIV_N) begin
          // load the denominator product for the second division
          res_num <= neg ? WORK_W'(-q_next) : WORK_W'(q_next);
          dvd     <= y;
          rem     <= '0;
          cnt     <= '0;
        end else begin
          rem <= alu.ge ? alu.diff[WORK_W-1:0] : rem_sh[WORK_W-1:0];
          dvd <= q_next;
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            res_den <= q_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res.sum_num   = rac_pkg::SUM_NUM_W'(res_num);
  assign res.sum_den   = rac_pkg::SUM_DEN_W'(res_den);
  assign res.a_less_b  = less;
  assign res.a_equal_b = eq;

  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::S_IDLE && start) |=> (state == rac_pkg::S_MUL_A))
    else $error("accepted request did not start the multiply sequence");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::S_DIV_N || state == rac_pkg::S_DIV_D) |-> (g != '0))
    else $error("divide started with a zero gcd");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::S_DIV_N || state == rac_pkg::S_DIV_D) |-> (rem < g))
    else $error("partial remainder not below divisor");

  a_gcd_odd_step: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::S_GCD && !gcd_stop && u[0] && v[0])
      |=> (state == rac_pkg::S_GCD) && (u == $past(u) || v == $past(v)))
    else $error("gcd subtract step touched both operands");

  a_done_den: assert property (@(posedge clk) disable iff (rst)
    (state == rac_pkg::S_DONE && !y_zero) |-> (res_den != '0))
    else $error("nonzero denominator product reduced to zero");

endmodule

FILE: hdl/rational_add_compare_unit.sv
// channel  dir  bits  fields (low bit first)
// s        in   64    a_num[15:0] a_den[30:16] b_num[46:31] b_den[61:47] pad[63:62]
// m        out  64    sum_num[31:0] sum_den[61:32] a_less_b[62] a_equal_b[63]
//
// One request at a time. The time from acceptance to result is set by the
// shared subtract unit (binary gcd, at least one bit removed per cycle, then two
// 32-step restoring divisions). A zero denominator skips the divisions.
// rst is synchronous, active high, and returns the sequencer to idle.
// A held result sits in the output register; the next request is taken meanwhile,
// and the sequencer waits at its end until the output register is free.
module rational_add_compare_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rac_pkg::IN_TDATA_W-1:0]     s_tdata,   // a_num, a_den, b_num, b_den
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rac_pkg::OUT_TDATA_W-1:0]    m_tdata    // sum_num, sum_den, a_less_b, a_equal_b
);

  localparam int NUM_W = rac_pkg::NUM_W;
  localparam int DEN_W = rac_pkg::DEN_W;

  logic                 core_ready;
  logic                 res_valid;
  logic                 res_ready;
  rac_pkg::rac_result_t res;

  assign s_tready  = core_ready;
  assign res_ready = !m_tvalid || m_tready;

  rac_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (s_tvalid),
    .in_a_num  (s_tdata[NUM_W-1:0]),
    .in_a_den  (s_tdata[NUM_W+DEN_W-1:NUM_W]),
    .in_b_num  (s_tdata[2*NUM_W+DEN_W-1:NUM_W+DEN_W]),
    .in_b_den  (s_tdata[2*NUM_W+2*DEN_W-1:2*NUM_W+DEN_W]),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= rac_pkg::OUT_TDATA_W'({res.a_equal_b, res.a_less_b, res.sum_den, res.sum_num});
    end
  end

endmodule

FILE: dv/rational_add_compare_unit_tb.sv
module rational_add_compare_unit_tb;

  localparam int NUM_W       = rac_pkg::NUM_W;
  localparam int DEN_W       = rac_pkg::DEN_W;
  localparam int SUM_NUM_W   = rac_pkg::SUM_NUM_W;
  localparam int SUM_DEN_W   = rac_pkg::SUM_DEN_W;
  localparam int IN_DATA_W   = rac_pkg::IN_DATA_W;
  localparam int IN_TDATA_W  = rac_pkg::IN_TDATA_W;
  localparam int OUT_DATA_W  = rac_pkg::OUT_DATA_W;
  localparam int OUT_TDATA_W = rac_pkg::OUT_TDATA_W;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int MAX_REPORTS    = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;    // a_num, a_den, b_num, b_den
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // sum_num, sum_den, a_less_b, a_equal_b

  rac_pkg::rac_result_t pending_sums[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int bad_results = 0;
  int zero_den_sent = 0;
  int equal_sent = 0;
  int quiet_cycles = 0;

  rational_add_compare_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Exact sum over the cross product, reduced by the remainder-loop gcd.
  function automatic rac_pkg::rac_result_t predict_sum(input logic signed [NUM_W-1:0] an,
                                                       input logic [DEN_W-1:0] ad,
                                                       input logic signed [NUM_W-1:0] bn,
                                                       input logic [DEN_W-1:0] bd);
    longint cross_a, cross_b, x;
    longint unsigned y, xm, u, v, t, q, rn, rd;
    rac_pkg::rac_result_t r;
    cross_a = longint'(an) * longint'(bd);
    cross_b = longint'(bn) * longint'(ad);
    x = cross_a + cross_b;
    y = longint'(ad) * longint'(bd);
    xm = (x < 0) ? -x : x;
    u = xm;
    v = y;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    if (u == 0) begin
      rn = 0;
      rd = 0;
    end else if (y == 0) begin
      rn = 1;
      rd = 0;
    end else begin
      q = xm / u;
      rn = (x < 0) ? -q : q;
      rd = y / u;
    end
    r.sum_num   = rn[SUM_NUM_W-1:0];
    r.sum_den   = rd[SUM_DEN_W-1:0];
    r.a_less_b  = (cross_a < cross_b);
    r.a_equal_b = (an == bn) && (ad == bd);
    return r;
  endfunction

  task automatic send_request(input logic signed [NUM_W-1:0] an, input logic [DEN_W-1:0] ad,
                              input logic signed [NUM_W-1:0] bn, input logic [DEN_W-1:0] bd);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_DATA_W){1'b0}}, bd, bn, ad, an};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    pending_sums.push_back(predict_sum(an, ad, bn, bd));
    requests_sent++;
    if (ad == 0 || bd == 0) zero_den_sent++;
    if (an == bn && ad == bd) equal_sent++;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin : check_results
    rac_pkg::rac_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_DATA_W-1:0];
      results_checked++;
      if (pending_sums.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("unexpected result: num %0d den %0d lt %0b eq %0b",
                   got.sum_num, got.sum_den, got.a_less_b, got.a_equal_b);
      end else begin
        want = pending_sums.pop_front();
        if (got.sum_num !== want.sum_num || got.sum_den !== want.sum_den ||
            got.a_less_b !== want.a_less_b || got.a_equal_b !== want.a_equal_b) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display({"mismatch: want num %0d den %0d lt %0b eq %0b, ",
                      "got num %0d den %0d lt %0b eq %0b"},
                     want.sum_num, want.sum_den, want.a_less_b, want.a_equal_b,
                     got.sum_num, got.sum_den, got.a_less_b, got.a_equal_b);
        end
      end
    end
  end

  // Abort when neither side moves a request for too long.
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [DEN_W-1:0] pick_den();
    if ($urandom_range(99) < 3) return '0;
    return DEN_W'($urandom_range((1 << DEN_W) - 1, 1));
  endfunction

  task automatic test_extremes();
    send_request(16'sh7fff, 15'd1, 16'sh7fff, 15'd1);
    send_request(-16'sh8000, 15'd1, -16'sh8000, 15'd1);
    send_request(16'sh7fff, 15'h7fff, -16'sh8000, 15'h7fff);
    send_request(-16'sh8000, 15'd1, 16'sh7fff, 15'h7fff);
    send_request(16'sh7fff, 15'h7ffe, 16'sh7fff, 15'h7ffd);
    send_request(-16'sh8000, 15'h7ffe, -16'sh8000, 15'h7fff);
    send_request(16'sd0, 15'd1, 16'sd0, 15'd1);
    send_request(-16'sd1, 15'h7fff, 16'sd1, 15'h7fff);
    send_request(16'sd1, 15'd2, 16'sd1, 15'd3);
  endtask

  task automatic test_special_cases();
    // zero sum reduces to 0/1
    send_request(16'sd3, 15'd4, -16'sd3, 15'd4);
    // zero denominator with a nonzero cross sum and with a zero one
    send_request(16'sd5, 15'd0, 16'sd3, 15'd7);
    send_request(16'sd7, 15'd3, -16'sd2, 15'd0);
    send_request(16'sd0, 15'd0, 16'sd3, 15'd0);
    send_request(16'sd0, 15'd0, 16'sd0, 15'd5);
    send_request(-16'sd4, 15'd0, 16'sd5, 15'd0);
    send_request(-16'sh8000, 15'd0, 16'sh7fff, 15'd9);
    // equality is field-wise: 1/2 and 2/4 are not equal
    send_request(16'sd7, 15'd9, 16'sd7, 15'd9);
    send_request(16'sd1, 15'd2, 16'sd2, 15'd4);
    send_request(16'sd1, 15'd6, 16'sd1, 15'd3);
    send_request(-16'sd1, 15'd2, 16'sd1, 15'd3);
    send_request(16'sd1, 15'd3, -16'sd1, 15'd2);
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    logic signed [NUM_W-1:0] an, bn;
    logic [DEN_W-1:0] ad, bd, k;
    int mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(99);
      an = NUM_W'($urandom);
      bn = NUM_W'($urandom);
      ad = pick_den();
      bd = pick_den();
      if (mode < 25) begin
        // small operands: lots of reduction and sign mixing
        an = NUM_W'($urandom_range(40)) - 16'sd20;
        bn = NUM_W'($urandom_range(40)) - 16'sd20;
        ad = DEN_W'($urandom_range(24, 1));
        bd = DEN_W'($urandom_range(24, 1));
      end else if (mode < 35) begin
        bn = an;
        bd = ad;
      end else if (mode < 45) begin
        bn = -an;
        bd = ad;
      end else if (mode < 60) begin
        // denominators sharing a factor
        k = DEN_W'($urandom_range(180, 2));
        ad = k * DEN_W'($urandom_range(180, 1));
        bd = k * DEN_W'($urandom_range(180, 1));
      end else if (mode < 68) begin
        an = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
        bn = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
        ad = $urandom_range(1) ? 15'h7fff : 15'd1;
        bd = $urandom_range(1) ? 15'h7fff : 15'h7ffe;
      end
      send_request(an, ad, bn, bd);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 69;
    test_extremes();
    test_special_cases();
    test_random(240, 16, 69);
    test_random(240, 69, 16);
    test_random(250, 0, 0);
    s_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests (%0d with a zero denominator, %0d identical pairs),",
             requests_sent, zero_den_sent, equal_sent);
    $display("%0d results checked under three handshake pacing mixes, %0d bad",
             results_checked, bad_results);
    if (bad_results == 0 && pending_sums.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
